// ===== rtl/core/binary_message_framer_fletcher8_top_defines.svh =====
// ----------------------------------------------------------------------------
// Framer assertion macros
// Shared property forms for the framer checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_MESSAGE_FRAMER_FLETCHER8_TOP_DEFINES_SVH
`define BINARY_MESSAGE_FRAMER_FLETCHER8_TOP_DEFINES_SVH

// Same-cycle implication, off during reset
`define BMF8_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed");

// Next-cycle implication, off during reset
`define BMF8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed");

`endif

// ===== rtl/core/bmf8_pkg.sv =====
// ----------------------------------------------------------------------------
// Framer package
// Codes, constants and the result burst type of the Fletcher-8 framer.
// ----------------------------------------------------------------------------
package bmf8_pkg;

   localparam int MAX_RESULTS = 8;
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_PAYLOAD = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_FRAME   = 2'd1,
      STATUS_FRAME_OPEN = 2'd2
   } status_type;

   // All results caused by one request
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [IDX_W-1:0]            last_idx;
      logic                        eop;
      status_type                  status;
   } burst_type;

endpackage

// ===== rtl/core/bmf8_req_if.sv =====
// ----------------------------------------------------------------------------
// Framer request channel
// Valid/ready channel carrying one start or payload request.
// ----------------------------------------------------------------------------
interface bmf8_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  msg_class;
   logic [7:0]  msg_id;
   logic [15:0] payload_length;
   logic [7:0]  data_byte;

   modport source (output valid, opcode, msg_class, msg_id, payload_length, data_byte,
                   input ready);
   modport sink   (input valid, opcode, msg_class, msg_id, payload_length, data_byte,
                   output ready);
endinterface

// ===== rtl/core/bmf8_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Framer result channel
// Valid/ready channel carrying one framed output byte.
// ----------------------------------------------------------------------------
interface bmf8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_packet;
   logic       last_of_run;
   logic [1:0] status;

   modport source (output valid, out_byte, end_of_packet, last_of_run, status,
                   input ready);
   modport sink   (input valid, out_byte, end_of_packet, last_of_run, status,
                   output ready);
endinterface

// ===== rtl/core/binary_message_framer_fletcher8_top.sv =====
// The first result of a request is valid the cycle after acceptance.
// Throughput: a start yields 6 or 8 results, a payload 1 or 3, a refusal 1,
// sent one per cycle while the receiver is ready; the next request is taken
// with the previous one's last result, so one-result requests pass one a cycle.
// Reset: clears the open-frame flag, byte count, both sums and result valid.
// ----------------------------------------------------------------------------
// Fletcher-8 message framer
// Wraps header and payload bytes into sync-prefixed, checksummed frames.
// ----------------------------------------------------------------------------
module binary_message_framer_fletcher8_top (
   input  logic       clock,
   input  logic       reset,
   bmf8_req_if.sink   req_ch,
   bmf8_rsp_if.source rsp_ch
);

   bmf8_pkg::burst_type burst;
   logic                can_load;
   logic                load;

   assign req_ch.ready = can_load;
   assign load         = req_ch.valid & can_load;

   // Form all results of the request
   bmf8_build u_build (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .opcode         (req_ch.opcode),
      .msg_class      (req_ch.msg_class),
      .msg_id         (req_ch.msg_id),
      .payload_length (req_ch.payload_length),
      .data_byte      (req_ch.data_byte),
      .burst          (burst)
   );

   // Send them one byte a cycle while the receiver is ready
   bmf8_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .burst         (burst),
      .can_load      (can_load),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .out_byte      (rsp_ch.out_byte),
      .end_of_packet (rsp_ch.end_of_packet),
      .last_of_run   (rsp_ch.last_of_run),
      .status        (rsp_ch.status)
   );

endmodule

// ===== rtl/core/bmf8_build.sv =====
// ----------------------------------------------------------------------------
// Framer burst builder
// Holds the frame state and running sums, forms all bytes of one request.
// ----------------------------------------------------------------------------
module bmf8_build (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 opcode,
   input  logic [7:0]           msg_class,
   input  logic [7:0]           msg_id,
   input  logic [15:0]          payload_length,
   input  logic [7:0]           data_byte,
   output bmf8_pkg::burst_type  burst
);

   logic        frame_open_ff, frame_open_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;

   logic [7:0] hdr_a1, hdr_a2, hdr_a3, hdr_a4;
   logic [7:0] hdr_b2, hdr_b3, hdr_b4;
   logic [7:0] pay_a, pay_b;
   logic       len_zero, pay_last;

   // Fletcher chain over the four header bytes
   assign hdr_a1 = msg_class;
   assign hdr_a2 = hdr_a1 + msg_id;
   assign hdr_b2 = hdr_a1 + hdr_a2;
   assign hdr_a3 = hdr_a2 + payload_length[7:0];
   assign hdr_b3 = hdr_b2 + hdr_a3;
   assign hdr_a4 = hdr_a3 + payload_length[15:8];
   assign hdr_b4 = hdr_b3 + hdr_a4;
   assign len_zero = (payload_length == 16'd0);

   // One step over a payload byte
   assign pay_a    = sum_a_ff + data_byte;
   assign pay_b    = sum_b_ff + pay_a;
   assign pay_last = (remaining_ff == 16'd1);

   // Form the burst and the next state
   always_comb begin
      burst          = '0;
      burst.status   = bmf8_pkg::STATUS_OK;
      frame_open_in  = frame_open_ff;
      remaining_in   = remaining_ff;
      sum_a_in       = sum_a_ff;
      sum_b_in       = sum_b_ff;
      if (opcode == bmf8_pkg::OP_START) begin
         if (frame_open_ff) begin
            burst.status = bmf8_pkg::STATUS_FRAME_OPEN;
         end else begin
            burst.data[0] = bmf8_pkg::SYNC_FIRST;
            burst.data[1] = bmf8_pkg::SYNC_SECOND;
            burst.data[2] = msg_class;
            burst.data[3] = msg_id;
            burst.data[4] = payload_length[7:0];
            burst.data[5] = payload_length[15:8];
            burst.data[6] = hdr_a4;
            burst.data[7] = hdr_b4;
            burst.last_idx = len_zero ? bmf8_pkg::IDX_W'(7) : bmf8_pkg::IDX_W'(5);
            burst.eop      = len_zero;
            sum_a_in       = hdr_a4;
            sum_b_in       = hdr_b4;
            frame_open_in  = !len_zero;
            remaining_in   = payload_length;
         end
      end else begin
         if (!frame_open_ff) begin
            burst.status = bmf8_pkg::STATUS_NO_FRAME;
         end else begin
            burst.data[0]  = data_byte;
            burst.data[1]  = pay_a;
            burst.data[2]  = pay_b;
            burst.last_idx = pay_last ? bmf8_pkg::IDX_W'(2) : bmf8_pkg::IDX_W'(0);
            burst.eop      = pay_last;
            sum_a_in       = pay_a;
            sum_b_in       = pay_b;
            remaining_in   = remaining_ff - 16'd1;
            frame_open_in  = !pay_last;
         end
      end
   end

   // Advance the frame state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
      end else if (load) begin
         frame_open_ff <= frame_open_in;
         remaining_ff  <= remaining_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
      end
   end

endmodule

// ===== rtl/core/bmf8_emit.sv =====
// ----------------------------------------------------------------------------
// Framer byte emitter
// Registers one burst and sends its bytes one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module bmf8_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  bmf8_pkg::burst_type burst,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          out_byte,
   output logic                end_of_packet,
   output logic                last_of_run,
   output logic [1:0]          status
);

   bmf8_pkg::burst_type           burst_ff, burst_in;
   logic [bmf8_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          busy_ff, busy_in;
   logic                          at_last, take;

   assign at_last  = (idx_ff == burst_ff.last_idx);
   assign take     = busy_ff & rsp_ready;
   assign can_load = !busy_ff | (take & at_last);

   // Load a new burst, or step through the current one
   always_comb begin
      burst_in = burst_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (load) begin
         burst_in = burst;
         idx_in   = '0;
         busy_in  = 1'b1;
      end else if (take) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // Hold the burst payload
   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

   assign rsp_valid     = busy_ff;
   assign out_byte      = burst_ff.data[idx_ff];
   assign end_of_packet = at_last & burst_ff.eop;
   assign last_of_run   = at_last;
   assign status        = burst_ff.status;

endmodule

// ===== rtl/core/bmf8_checker.sv =====
// ----------------------------------------------------------------------------
// Framer port checker
// Watches the framer ports for ordering and error-result rules.
// ----------------------------------------------------------------------------
`include "binary_message_framer_fletcher8_top_defines.svh"

module bmf8_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       end_of_packet,
   input logic       last_of_run,
   input logic [1:0] status
);

   // A stalled result keeps its byte
   `BMF8_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(out_byte))

   // An accepted request always shows a result next cycle
   `BMF8_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // Frame end closes the run and is never an error
   `BMF8_ASSERT_IMPLY(a_eop_last, clock, reset, rsp_valid && end_of_packet,
      last_of_run && status == bmf8_pkg::STATUS_OK)

   // Error results are single zero bytes
   `BMF8_ASSERT_IMPLY(a_err_form, clock, reset,
      rsp_valid && status != bmf8_pkg::STATUS_OK,
      out_byte == 8'd0 && last_of_run && !end_of_packet)

endmodule

bind binary_message_framer_fletcher8_top bmf8_checker u_bmf8_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .out_byte      (rsp_ch.out_byte),
   .end_of_packet (rsp_ch.end_of_packet),
   .last_of_run   (rsp_ch.last_of_run),
   .status        (rsp_ch.status)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Fletcher-8 message framer testbench
// Drives start and payload requests into the framer and checks every framed
// output byte against a shadow framer kept in the bench. A short directed
// sequence covers field extremes, zero-length frames and both refusal cases.
// A random run of mostly well-formed frames with some stray requests follows.
// Both sides idle in random bursts, and the receiver holds off once for a
// long stretch so the framer fills up and stalls its request side.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_PERIOD     = 4;
   localparam int RESET_CYCLES   = 4;
   localparam int RANDOM_ITEMS   = 200;
   localparam int TAIL_ITEMS     = 40;
   localparam int HOLD_AT        = 60;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      bmf8_pkg::opcode_type opcode;
      logic [7:0]           msg_class;
      logic [7:0]           msg_id;
      logic [15:0]          payload_length;
      logic [7:0]           data_byte;
   } request_type;

   typedef struct {
      logic [7:0]           out_byte;
      logic                 end_of_packet;
      logic                 last_of_run;
      bmf8_pkg::status_type status;
   } frame_byte_type;

   logic clock;
   logic reset;

   bmf8_req_if req_bus ();
   bmf8_rsp_if rsp_bus ();

   binary_message_framer_fletcher8_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   request_type    request_queue[$];
   frame_byte_type frame_bytes_q[$];

   // Shadow framer state
   logic        shadow_open      = 1'b0;
   logic [15:0] shadow_remaining = '0;
   logic [7:0]  shadow_sum_a     = '0;
   logic [7:0]  shadow_sum_b     = '0;

   int req_sent_cnt   = 0;
   int req_taken_cnt  = 0;
   int bytes_checked  = 0;
   int frames_closed  = 0;
   int refused_cnt    = 0;
   int mismatch_count = 0;

   int send_gap       = 0;
   int send_segment   = 0;
   bit send_idle_mode = 1'b0;
   int recv_gap       = 0;
   int recv_segment   = 0;
   bit recv_idle_mode = 1'b0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   // Count a failure, report only the first few
   function automatic void note_failure(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endfunction

   function automatic void push_frame_byte(logic [7:0] b, logic eop,
                                           bmf8_pkg::status_type st);
      frame_byte_type fb;
      fb.out_byte      = b;
      fb.end_of_packet = eop;
      fb.last_of_run   = 1'b0;
      fb.status        = st;
      frame_bytes_q.push_back(fb);
   endfunction

   // Fold one byte into both running sums, then emit it
   function automatic void push_summed(logic [7:0] b);
      shadow_sum_a = shadow_sum_a + b;
      shadow_sum_b = shadow_sum_b + shadow_sum_a;
      push_frame_byte(b, 1'b0, bmf8_pkg::STATUS_OK);
   endfunction

   function automatic void push_checksum();
      push_frame_byte(shadow_sum_a, 1'b0, bmf8_pkg::STATUS_OK);
      push_frame_byte(shadow_sum_b, 1'b1, bmf8_pkg::STATUS_OK);
   endfunction

   // Work out the framed bytes one accepted request produces
   function automatic void predict_frame_bytes(request_type r);
      if (r.opcode == bmf8_pkg::OP_START) begin
         if (shadow_open) begin
            push_frame_byte(8'h00, 1'b0, bmf8_pkg::STATUS_FRAME_OPEN);
         end else begin
            shadow_sum_a = '0;
            shadow_sum_b = '0;
            push_frame_byte(bmf8_pkg::SYNC_FIRST, 1'b0, bmf8_pkg::STATUS_OK);
            push_frame_byte(bmf8_pkg::SYNC_SECOND, 1'b0, bmf8_pkg::STATUS_OK);
            push_summed(r.msg_class);
            push_summed(r.msg_id);
            push_summed(r.payload_length[7:0]);
            push_summed(r.payload_length[15:8]);
            if (r.payload_length == 16'd0) begin
               push_checksum();
            end else begin
               shadow_open      = 1'b1;
               shadow_remaining = r.payload_length;
            end
         end
      end else begin
         if (!shadow_open) begin
            push_frame_byte(8'h00, 1'b0, bmf8_pkg::STATUS_NO_FRAME);
         end else begin
            push_summed(r.data_byte);
            shadow_remaining = shadow_remaining - 16'd1;
            if (shadow_remaining == 16'd0) begin
               push_checksum();
               shadow_open = 1'b0;
            end
         end
      end
      frame_bytes_q[frame_bytes_q.size() - 1].last_of_run = 1'b1;
   endfunction

   // Queue a start request; the payload byte field carries noise
   function automatic void add_start(logic [7:0] cls, logic [7:0] id, logic [15:0] len);
      request_type r;
      r.opcode         = bmf8_pkg::OP_START;
      r.msg_class      = cls;
      r.msg_id         = id;
      r.payload_length = len;
      r.data_byte      = 8'($urandom_range(0, 255));
      request_queue.push_back(r);
   endfunction

   // Queue a payload request; the header fields carry noise
   function automatic void add_payload(logic [7:0] b);
      request_type r;
      r.opcode         = bmf8_pkg::OP_PAYLOAD;
      r.msg_class      = 8'($urandom_range(0, 255));
      r.msg_id         = 8'($urandom_range(0, 255));
      r.payload_length = 16'($urandom_range(0, 65535));
      r.data_byte      = b;
      request_queue.push_back(r);
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog
   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("binary_message_framer_fletcher8_top test failed");
      $finish;
   end

   // Monitor: predict on each accepted request, check each accepted byte
   always @(posedge clock) begin : monitor
      request_type    seen;
      frame_byte_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.opcode         = bmf8_pkg::opcode_type'(req_bus.opcode);
            seen.msg_class      = req_bus.msg_class;
            seen.msg_id         = req_bus.msg_id;
            seen.payload_length = req_bus.payload_length;
            seen.data_byte      = req_bus.data_byte;
            predict_frame_bytes(seen);
            req_taken_cnt++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            bytes_checked++;
            if (frame_bytes_q.size() == 0) begin
               note_failure($sformatf("unexpected byte %02h eop=%0b last=%0b status=%0d",
                  rsp_bus.out_byte, rsp_bus.end_of_packet, rsp_bus.last_of_run,
                  rsp_bus.status));
            end else begin
               want = frame_bytes_q.pop_front();
               if (rsp_bus.out_byte !== want.out_byte ||
                   rsp_bus.end_of_packet !== want.end_of_packet ||
                   rsp_bus.last_of_run !== want.last_of_run ||
                   rsp_bus.status !== want.status) begin
                  note_failure($sformatf({"byte %0d: expected %02h eop=%0b last=%0b ",
                     "status=%0d, got %02h eop=%0b last=%0b status=%0d"}, bytes_checked,
                     want.out_byte, want.end_of_packet, want.last_of_run, want.status,
                     rsp_bus.out_byte, rsp_bus.end_of_packet, rsp_bus.last_of_run,
                     rsp_bus.status));
               end
               if (want.end_of_packet) frames_closed++;
               if (want.status != bmf8_pkg::STATUS_OK) refused_cnt++;
            end
         end
      end
   end

   // Driver: present queued requests, hold each until accepted
   always @(negedge clock) begin : driver
      request_type nxt;
      bit          quiet;
      quiet = (request_queue.size() < TAIL_ITEMS);
      if (send_segment == 0) begin
         send_segment   = $urandom_range(40, 250);
         send_idle_mode = ($urandom_range(0, 2) != 0);
      end else begin
         send_segment--;
      end
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && req_taken_cnt != req_sent_cnt) begin
         // hold the current request
      end else if (send_gap > 0 && !quiet) begin
         send_gap--;
         req_bus.valid <= 1'b0;
      end else if (request_queue.size() == 0) begin
         req_bus.valid <= 1'b0;
      end else if (!quiet && send_idle_mode && $urandom_range(0, 5) == 0) begin
         send_gap = $urandom_range(1, 19) - 1;
         req_bus.valid <= 1'b0;
      end else begin
         nxt = request_queue.pop_front();
         req_bus.opcode         <= nxt.opcode;
         req_bus.msg_class      <= nxt.msg_class;
         req_bus.msg_id         <= nxt.msg_id;
         req_bus.payload_length <= nxt.payload_length;
         req_bus.data_byte      <= nxt.data_byte;
         req_bus.valid          <= 1'b1;
         req_sent_cnt++;
      end
   end

   // Receiver: random stalls plus one long hold-off
   always @(negedge clock) begin : receiver
      bit quiet;
      quiet = (request_queue.size() < TAIL_ITEMS);
      if (recv_segment == 0) begin
         recv_segment   = $urandom_range(40, 250);
         recv_idle_mode = ($urandom_range(0, 2) != 0);
      end else begin
         recv_segment--;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && bytes_checked >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0 && !quiet) begin
         recv_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && recv_idle_mode && $urandom_range(0, 4) == 0) begin
         recv_gap = $urandom_range(1, 19) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Stimulus, reset and end of run
   initial begin : stimulus
      int sel;
      int len;
      int target;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.opcode         = bmf8_pkg::OP_START;
      req_bus.msg_class      = '0;
      req_bus.msg_id         = '0;
      req_bus.payload_length = '0;
      req_bus.data_byte      = '0;
      rsp_bus.ready          = 1'b0;

      // Directed: stray payload, empty frames at both extremes, refusals mid-frame
      add_payload(8'hFF);
      add_start(8'h00, 8'h00, 16'h0000);
      add_start(8'hFF, 8'hFF, 16'h0000);
      add_start(8'h06, 8'h01, 16'h0003);
      add_payload(8'h00);
      add_start(8'hFF, 8'hFF, 16'hFFFF);
      add_payload(8'hFF);
      add_payload(8'h00);
      add_payload(8'h00);
      add_start(8'h0A, 8'h04, 16'h0001);
      add_payload(8'h80);
      add_start(8'h55, 8'hAA, 16'h0002);
      add_payload(8'hA5);
      add_payload(8'h5A);
      add_payload(8'h01);
      add_start(8'h80, 8'h7F, 16'h0040);
      for (int i = 0; i < 64; i++) add_payload(8'(i * 4 + 3));

      // Random: mostly well-formed frames, some stray requests
      target = request_queue.size() + RANDOM_ITEMS;
      while (request_queue.size() < target) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            add_payload(8'($urandom_range(0, 255)));
         end else begin
            sel = $urandom_range(0, 19);
            if (sel < 3)       len = 0;
            else if (sel < 15) len = $urandom_range(1, 8);
            else if (sel < 19) len = $urandom_range(9, 40);
            else               len = $urandom_range(41, 120);
            add_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 29) == 0) begin
                  add_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)));
               end
               add_payload(8'($urandom_range(0, 255)));
            end
         end
      end

      // Tail: open a maximum-length frame and leave it open
      add_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'hFFFF);
      add_payload(8'h00);
      add_payload(8'hFF);
      add_payload(8'($urandom_range(0, 255)));
      add_start(8'h00, 8'h00, 16'h0000);
      add_payload(8'($urandom_range(0, 255)));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Drain all requests and expected bytes
      while (request_queue.size() != 0 || req_taken_cnt != req_sent_cnt ||
             frame_bytes_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d framed bytes checked.",
               req_taken_cnt, bytes_checked);
      $display("Frames closed: %0d, refused requests: %0d, mismatches: %0d.",
               frames_closed, refused_cnt, mismatch_count);
      if (mismatch_count == 0 && frame_bytes_q.size() == 0) begin
         $display("binary_message_framer_fletcher8_top test passed");
      end else begin
         $display("binary_message_framer_fletcher8_top test failed");
      end
      $finish;
   end

endmodule
